// ===== design/mag_flip_offset_calibrator_macros.svh =====
// assertion macros for the magnetometer offset calibrator checker
// no dependencies; included by the checker file
`ifndef MAG_FLIP_OFFSET_CALIBRATOR_MACROS_SVH
`define MAG_FLIP_OFFSET_CALIBRATOR_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define MFOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define MFOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mfoc_pkg.sv =====
// shared types and constants for the magnetometer offset calibrator
// no dependencies; used by the interfaces and all modules
package mfoc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int EXT_W     = SUM_W - SAMPLE_W;
    localparam int COUNT_W   = 9;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int STEP_W    = 3;
    localparam int HALF_W    = SUM_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [STEP_W-1:0]  LAST_STEP       = STEP_W'(2 * AXES - 1);
    localparam logic [COUNT_W-1:0] DEFAULT_SAMPLES = COUNT_W'(3);

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_PULSE  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        logic              load;
        logic              clear;
        logic              acc_norm;
        logic              acc_inv;
        logic              emit;
        t_kind             kind;
        logic              last;
        logic              pulse_level;
        logic              div_start;
        logic [AXIS_W-1:0] axis;
        logic              div_inv;
        logic              half;
        logic              offs;
    } t_dp_cmd;

    typedef struct packed {
        logic               item_cmd;
        logic [COUNT_W-1:0] item_count;
        logic               div_done;
        logic               out_free;
    } t_dp_status;

endpackage

// ===== design/mfoc_in_if.sv =====
// input channel: sample or start-calibration word with valid/ready
// depends on mfoc_pkg
interface mfoc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] sample_x;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] sample_y;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] sample_z;
    logic [mfoc_pkg::COUNT_W-1:0]         calib_count;

    modport source (output valid, command, sample_x, sample_y, sample_z, calib_count,
                    input ready);
    modport sink (input valid, command, sample_x, sample_y, sample_z, calib_count,
                  output ready);
endinterface

// ===== design/mfoc_out_if.sv =====
// output channel: result word with valid/ready
// depends on mfoc_pkg
interface mfoc_out_if;
    logic                                 valid;
    logic                                 ready;
    mfoc_pkg::t_kind                      kind;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] out_x;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] out_y;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] out_z;
    logic                                 pulse_level;
    logic                                 last;

    modport source (output valid, kind, out_x, out_y, out_z, pulse_level, last,
                    input ready);
    modport sink (input valid, kind, out_x, out_y, out_z, pulse_level, last,
                  output ready);
endinterface

// ===== design/mfoc_div.sv =====
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
// depends on mfoc_pkg
module mfoc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mfoc_pkg::SUM_W-1:0]   i_dividend,
    input  logic [mfoc_pkg::COUNT_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic signed [mfoc_pkg::SUM_W-1:0]   o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_neg;
    logic [mfoc_pkg::SUM_W-1:0]         r_mag;
    logic [mfoc_pkg::COUNT_W-1:0]       r_rem;
    logic [mfoc_pkg::COUNT_W-1:0]       r_den;
    logic [mfoc_pkg::DIV_CNT_W-1:0]     r_cnt;

    logic [mfoc_pkg::COUNT_W:0]         w_shift;
    logic [mfoc_pkg::COUNT_W:0]         w_trial;
    logic                               w_fits;

    assign w_shift = {r_rem, r_mag[mfoc_pkg::SUM_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_fits  = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_dividend[mfoc_pkg::SUM_W-1];
                r_mag  <= i_dividend[mfoc_pkg::SUM_W-1] ? -i_dividend : i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= mfoc_pkg::DIV_CNT_W'(mfoc_pkg::SUM_W);
            end else if (r_busy) begin
                r_rem <= w_fits ? w_trial[mfoc_pkg::COUNT_W-1:0]
                                : w_shift[mfoc_pkg::COUNT_W-1:0];
                r_mag <= {r_mag[mfoc_pkg::SUM_W-2:0], w_fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mfoc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_mag : r_mag;

endmodule

// ===== design/mfoc_dp.sv =====
// datapath: item latch, phase sums, offsets, divider, offset math and output register
// depends on mfoc_pkg and mfoc_div
module mfoc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_command,
    input  logic signed [mfoc_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic signed [mfoc_pkg::SAMPLE_W-1:0] i_sample_y,
    input  logic signed [mfoc_pkg::SAMPLE_W-1:0] i_sample_z,
    input  logic [mfoc_pkg::COUNT_W-1:0]         i_calib_count,
    input  logic [mfoc_pkg::COUNT_W-1:0]         i_divisor,
    input  mfoc_pkg::t_dp_cmd                    i_cmd,
    output mfoc_pkg::t_dp_status                 o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output mfoc_pkg::t_kind                      o_kind,
    output logic signed [mfoc_pkg::SAMPLE_W-1:0] o_out_x,
    output logic signed [mfoc_pkg::SAMPLE_W-1:0] o_out_y,
    output logic signed [mfoc_pkg::SAMPLE_W-1:0] o_out_z,
    output logic                                 o_pulse_level,
    output logic                                 o_last
);

    logic                                 r_item_cmd;
    logic [mfoc_pkg::COUNT_W-1:0]         r_item_count;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] r_smp  [mfoc_pkg::AXES];
    logic signed [mfoc_pkg::SUM_W-1:0]    r_nsum [mfoc_pkg::AXES];
    logic signed [mfoc_pkg::SUM_W-1:0]    r_isum [mfoc_pkg::AXES];
    logic signed [mfoc_pkg::SAMPLE_W-1:0] r_off  [mfoc_pkg::AXES];
    logic signed [mfoc_pkg::SUM_W-1:0]    r_avg_n;
    logic signed [mfoc_pkg::SUM_W-1:0]    r_avg_i;
    logic signed [mfoc_pkg::HALF_W-1:0]   r_half;

    logic                                 r_out_valid;
    mfoc_pkg::t_kind                      r_kind;
    logic signed [mfoc_pkg::SAMPLE_W-1:0] r_out [mfoc_pkg::AXES];
    logic                                 r_pulse_level;
    logic                                 r_last;

    logic signed [mfoc_pkg::SUM_W-1:0]    w_ext  [mfoc_pkg::AXES];
    logic signed [mfoc_pkg::SAMPLE_W-1:0] w_emit [mfoc_pkg::AXES];
    logic signed [mfoc_pkg::SUM_W-1:0]    w_dividend;
    logic                                 w_div_done;
    logic signed [mfoc_pkg::SUM_W-1:0]    w_quotient;
    logic signed [mfoc_pkg::HALF_W-1:0]   w_diff;
    logic signed [mfoc_pkg::HALF_W-1:0]   w_half;
    logic signed [mfoc_pkg::HALF_W-1:0]   w_offs;
    logic                                 w_out_free;

    assign w_dividend = i_cmd.div_inv ? r_isum[i_cmd.axis] : r_nsum[i_cmd.axis];

    mfoc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (i_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // difference halved toward zero
    assign w_diff = {r_avg_n[mfoc_pkg::SUM_W-1], r_avg_n}
                  - {r_avg_i[mfoc_pkg::SUM_W-1], r_avg_i};
    assign w_half = (w_diff >>> 1)
                  + mfoc_pkg::HALF_W'($signed({1'b0,
                        w_diff[mfoc_pkg::HALF_W-1] & w_diff[0]}));
    assign w_offs = r_half - {r_avg_n[mfoc_pkg::SUM_W-1], r_avg_n};

    always_comb begin
        for (int a = 0; a < mfoc_pkg::AXES; a++) begin
            w_ext[a] = {{mfoc_pkg::EXT_W{r_smp[a][mfoc_pkg::SAMPLE_W-1]}}, r_smp[a]};
            case (i_cmd.kind)
                mfoc_pkg::KIND_SAMPLE: w_emit[a] = r_smp[a] + r_off[a];
                mfoc_pkg::KIND_DONE:   w_emit[a] = r_off[a];
                default:               w_emit[a] = '0;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int a = 0; a < mfoc_pkg::AXES; a++) begin
                r_nsum[a] <= '0;
                r_isum[a] <= '0;
                r_off[a]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_item_cmd   <= i_command;
                r_item_count <= i_calib_count;
                r_smp[0]     <= i_sample_x;
                r_smp[1]     <= i_sample_y;
                r_smp[2]     <= i_sample_z;
            end
            for (int a = 0; a < mfoc_pkg::AXES; a++) begin
                if (i_cmd.clear) begin
                    r_nsum[a] <= '0;
                    r_isum[a] <= '0;
                    r_off[a]  <= '0;
                end
                if (i_cmd.acc_norm) begin
                    r_nsum[a] <= r_nsum[a] + w_ext[a];
                end
                if (i_cmd.acc_inv) begin
                    r_isum[a] <= r_isum[a] + w_ext[a];
                end
            end
            if (w_div_done) begin
                if (i_cmd.div_inv) begin
                    r_avg_i <= w_quotient;
                end else begin
                    r_avg_n <= w_quotient;
                end
            end
            if (i_cmd.half) begin
                r_half <= w_half;
            end
            if (i_cmd.offs) begin
                r_off[i_cmd.axis] <= w_offs[mfoc_pkg::SAMPLE_W-1:0];
            end
            if (i_cmd.emit) begin
                r_out_valid   <= 1'b1;
                r_kind        <= i_cmd.kind;
                r_pulse_level <= i_cmd.pulse_level;
                r_last        <= i_cmd.last;
                for (int a = 0; a < mfoc_pkg::AXES; a++) begin
                    r_out[a] <= w_emit[a];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.item_cmd   = r_item_cmd;
    assign o_status.item_count = r_item_count;
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_x       = r_out[0];
    assign o_out_y       = r_out[1];
    assign o_out_z       = r_out[2];
    assign o_pulse_level = r_pulse_level;
    assign o_last        = r_last;

endmodule

// ===== design/mfoc_ctrl.sv =====
// controller: calibration phases, pulse line, count register and division sequencing
// depends on mfoc_pkg; drives mfoc_dp through its command struct
module mfoc_ctrl #(
    parameter int unsigned MAX_SAMPLES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mfoc_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mfoc_pkg::t_dp_status          i_status,
    output mfoc_pkg::t_dp_cmd             o_cmd,
    output logic [mfoc_pkg::COUNT_W-1:0]  o_divisor
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_HALF,
        ST_OFFSET
    } t_state;

    typedef enum logic [1:0] {
        CAL_IDLE,
        CAL_NORMAL,
        CAL_INVERT
    } t_cal_mode;

    t_state                         r_state,   n_state;
    t_cal_mode                      r_mode,    n_mode;
    logic [mfoc_pkg::COUNT_W-1:0]   r_index,   n_index;
    logic [mfoc_pkg::COUNT_W-1:0]   r_target,  n_target;
    logic                           r_skip,    n_skip;
    logic                           r_pulse,   n_pulse;
    logic [mfoc_pkg::COUNT_W-1:0]   r_default, n_default;
    mfoc_pkg::t_kind                r_kind,    n_kind;
    logic                           r_last,    n_last;
    logic                           r_then_div, n_then_div;
    logic [mfoc_pkg::STEP_W-1:0]    r_step,    n_step;

    logic [mfoc_pkg::COUNT_W-1:0]   w_count;
    logic                           w_reject;
    logic [mfoc_pkg::COUNT_W-1:0]   w_next_idx;
    logic                           w_phase_end;

    assign w_count     = (i_status.item_count == '0) ? r_default : i_status.item_count;
    assign w_reject    = (r_mode != CAL_IDLE) || (w_count == '0)
                      || (32'(w_count) > 32'(MAX_SAMPLES));
    assign w_next_idx  = r_index + 1'b1;
    assign w_phase_end = (w_next_idx >= r_target);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_index    = r_index;
        n_target   = r_target;
        n_skip     = r_skip;
        n_pulse    = r_pulse;
        n_default  = i_cfg_we ? i_cfg_data : r_default;
        n_kind     = r_kind;
        n_last     = r_last;
        n_then_div = r_then_div;
        n_step     = r_step;

        o_cmd             = '0;
        o_cmd.kind        = r_kind;
        o_cmd.last        = r_last;
        o_cmd.pulse_level = r_pulse;
        o_cmd.axis        = r_step[mfoc_pkg::STEP_W-1:1];
        o_cmd.div_inv     = r_step[0];

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state    = ST_IDLE;
                n_then_div = 1'b0;
                n_last     = 1'b1;
                if (i_status.item_cmd) begin
                    if (w_reject) begin
                        n_kind  = mfoc_pkg::KIND_REJECT;
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_mode      = CAL_NORMAL;
                        n_index     = '0;
                        n_target    = w_count;
                        n_skip      = 1'b0;
                    end
                end else begin
                    case (r_mode)
                        CAL_NORMAL: begin
                            o_cmd.acc_norm = 1'b1;
                            n_index        = w_next_idx;
                            if (w_phase_end) begin
                                n_mode  = CAL_INVERT;
                                n_index = '0;
                                n_skip  = 1'b1;
                                n_pulse = !r_pulse;
                                n_kind  = mfoc_pkg::KIND_PULSE;
                                n_state = ST_EMIT;
                            end
                        end
                        CAL_INVERT: begin
                            if (r_skip) begin
                                n_skip = 1'b0;
                            end else begin
                                o_cmd.acc_inv = 1'b1;
                                n_index       = w_next_idx;
                                if (w_phase_end) begin
                                    n_mode     = CAL_IDLE;
                                    n_index    = '0;
                                    n_pulse    = !r_pulse;
                                    n_kind     = mfoc_pkg::KIND_PULSE;
                                    n_last     = 1'b0;
                                    n_then_div = 1'b1;
                                    n_state    = ST_EMIT;
                                end
                            end
                        end
                        default: begin
                            n_kind  = mfoc_pkg::KIND_SAMPLE;
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_then_div) begin
                        n_then_div = 1'b0;
                        n_step     = '0;
                        n_state    = ST_DIV_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (r_step[0]) begin
                        n_state = ST_HALF;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = ST_DIV_START;
                    end
                end
            end
            ST_HALF: begin
                o_cmd.half = 1'b1;
                n_state    = ST_OFFSET;
            end
            ST_OFFSET: begin
                o_cmd.offs = 1'b1;
                if (r_step == mfoc_pkg::LAST_STEP) begin
                    n_kind  = mfoc_pkg::KIND_DONE;
                    n_last  = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = ST_DIV_START;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= CAL_IDLE;
            r_index    <= '0;
            r_target   <= '0;
            r_skip     <= 1'b0;
            r_pulse    <= 1'b0;
            r_default  <= mfoc_pkg::DEFAULT_SAMPLES;
            r_kind     <= mfoc_pkg::KIND_SAMPLE;
            r_last     <= 1'b0;
            r_then_div <= 1'b0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_index    <= n_index;
            r_target   <= n_target;
            r_skip     <= n_skip;
            r_pulse    <= n_pulse;
            r_default  <= n_default;
            r_kind     <= n_kind;
            r_last     <= n_last;
            r_then_div <= n_then_div;
            r_step     <= n_step;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_divisor  = r_target;

endmodule

// ===== design/mag_flip_offset_calibrator.sv =====
// magnetometer set/reset offset calibrator, one three-axis channel
// plain sample: latched, decoded, then put in the output register once free; no new word until then
// word closing the inverted phase: pulse result first, then the offsets after six divider passes
//   (24 quotient bits each) plus a halving and an offset step per axis, and the emit
// reset (i_rst_n low, synchronous): idle, offsets and sums zero, pulse line low, count 3
module mag_flip_offset_calibrator #(
    parameter int unsigned MAX_SAMPLES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mfoc_pkg::COUNT_W-1:0]  i_cfg_data,
    mfoc_in_if.sink                       i_in,
    mfoc_out_if.source                    o_out
);

    mfoc_pkg::t_dp_cmd              w_cmd;
    mfoc_pkg::t_dp_status           w_status;
    logic [mfoc_pkg::COUNT_W-1:0]   w_divisor;
    logic                           w_in_ready;

    mfoc_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_divisor  (w_divisor)
    );

    mfoc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_in.command),
        .i_sample_x    (i_in.sample_x),
        .i_sample_y    (i_in.sample_y),
        .i_sample_z    (i_in.sample_z),
        .i_calib_count (i_in.calib_count),
        .i_divisor     (w_divisor),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_kind        (o_out.kind),
        .o_out_x       (o_out.out_x),
        .o_out_y       (o_out.out_y),
        .o_out_z       (o_out.out_z),
        .o_pulse_level (o_out.pulse_level),
        .o_last        (o_out.last)
    );

    assign i_in.ready = w_in_ready;

endmodule

// ===== design/mfoc_chk.sv =====
// port-level checker for the magnetometer offset calibrator, bound to the top level
// depends on mfoc_pkg and mag_flip_offset_calibrator_macros.svh
`include "mag_flip_offset_calibrator_macros.svh"

module mfoc_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [1:0]                           i_out_kind,
    input logic signed [mfoc_pkg::SAMPLE_W-1:0] i_out_x,
    input logic                                 i_out_last
);

    // stalled word holds
    `MFOC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_x) && $stable(i_out_last), "mfoc: stalled result changed")

    // only the pulse word ahead of the offsets is not last
    `MFOC_ASSERT_NOW(a_nonlast_pulse, i_clk, i_rst_n, i_out_valid && !i_out_last, i_out_kind == mfoc_pkg::KIND_PULSE, "mfoc: non-last result is not a pulse")

    // no new word taken while the offset result is still owed
    `MFOC_ASSERT_NOW(a_nonlast_block, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready, "mfoc: input taken while offsets pending")

    // offsets never follow the pulse word in the next cycle
    `MFOC_ASSERT_NEXT(a_div_gap, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, !i_out_valid, "mfoc: offsets emitted without division time")

endmodule

bind mag_flip_offset_calibrator mfoc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_x     (o_out.out_x),
    .i_out_last  (o_out.last)
);

// ===== tb/sv/tb.sv =====
// testbench for mag_flip_offset_calibrator: directed and random sample/calibration traffic
// with random gaps and stalls, each result checked against an in-bench model of the offsets
// depends on mfoc_pkg, mfoc_in_if, mfoc_out_if and the calibrator rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COUNT     = 256;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_WORDS  = 60;

    typedef enum logic [1:0] {
        CAL_IDLE     = 2'd0,
        CAL_NORMAL   = 2'd1,
        CAL_INVERTED = 2'd2
    } t_cal_state;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [8:0]         count;
    } t_in_word;

    typedef struct packed {
        mfoc_pkg::t_kind    kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               pulse;
        logic               last;
    } t_result_word;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_data;

    mfoc_in_if  in_if ();
    mfoc_out_if out_if ();

    mag_flip_offset_calibrator u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // model state
    logic [8:0]         dflt_count;
    t_cal_state         cal_state;
    int                 phase_seen;
    int                 phase_len;
    bit                 drop_next;
    logic               pulse_line;
    logic signed [23:0] norm_sum [3];
    logic signed [23:0] inv_sum [3];
    logic signed [15:0] axis_offs [3];

    t_result_word expected_results[$];
    t_result_word want;
    int           errors;
    int           words_sent;
    bit           no_idle;
    int           stall_left;
    int           stall_pick;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_delay(input int pct_zero);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < pct_zero)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void push_result(input mfoc_pkg::t_kind k,
                                        input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic signed [15:0] z, input logic last);
        t_result_word r;
        r.kind  = k;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.pulse = pulse_line;
        r.last  = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_word(input t_in_word w);
        logic signed [15:0] s [3];
        int                 eff;
        longint             avg_n;
        longint             avg_i;
        longint             half;
        s[0] = w.x;
        s[1] = w.y;
        s[2] = w.z;
        if (w.cmd) begin
            eff = (w.count == 0) ? int'(dflt_count) : int'(w.count);
            if (cal_state != CAL_IDLE || eff == 0 || eff > MAX_COUNT) begin
                push_result(mfoc_pkg::KIND_REJECT, 16'sd0, 16'sd0, 16'sd0, 1'b1);
            end else begin
                cal_state  = CAL_NORMAL;
                phase_seen = 0;
                phase_len  = eff;
                drop_next  = 1'b0;
                for (int a = 0; a < 3; a++) begin
                    norm_sum[a]  = '0;
                    inv_sum[a]   = '0;
                    axis_offs[a] = '0;
                end
            end
            return;
        end
        case (cal_state)
            CAL_NORMAL: begin
                for (int a = 0; a < 3; a++)
                    norm_sum[a] = norm_sum[a] + s[a];
                phase_seen++;
                if (phase_seen >= phase_len) begin
                    cal_state  = CAL_INVERTED;
                    phase_seen = 0;
                    drop_next  = 1'b1;
                    pulse_line = ~pulse_line;
                    push_result(mfoc_pkg::KIND_PULSE, 16'sd0, 16'sd0, 16'sd0, 1'b1);
                end
            end
            CAL_INVERTED: begin
                if (drop_next) begin
                    drop_next = 1'b0;
                end else begin
                    for (int a = 0; a < 3; a++)
                        inv_sum[a] = inv_sum[a] + s[a];
                    phase_seen++;
                    if (phase_seen >= phase_len) begin
                        cal_state  = CAL_IDLE;
                        phase_seen = 0;
                        pulse_line = ~pulse_line;
                        for (int a = 0; a < 3; a++) begin
                            avg_n        = longint'(norm_sum[a]) / longint'(phase_len);
                            avg_i        = longint'(inv_sum[a]) / longint'(phase_len);
                            half         = (avg_n - avg_i) / 2;
                            axis_offs[a] = 16'(half - avg_n);
                        end
                        push_result(mfoc_pkg::KIND_PULSE, 16'sd0, 16'sd0, 16'sd0, 1'b0);
                        push_result(mfoc_pkg::KIND_DONE, axis_offs[0], axis_offs[1],
                                    axis_offs[2], 1'b1);
                    end
                end
            end
            default: begin
                push_result(mfoc_pkg::KIND_SAMPLE, 16'(s[0] + axis_offs[0]),
                            16'(s[1] + axis_offs[1]), 16'(s[2] + axis_offs[2]), 1'b1);
            end
        endcase
    endfunction

    function automatic t_in_word sample_word(input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic signed [15:0] z);
        t_in_word w;
        w.cmd   = 1'b0;
        w.x     = x;
        w.y     = y;
        w.z     = z;
        w.count = 9'($urandom);
        return w;
    endfunction

    function automatic t_in_word start_word(input logic [8:0] count);
        t_in_word w;
        w.cmd   = 1'b1;
        w.x     = 16'($urandom);
        w.y     = 16'($urandom);
        w.z     = 16'($urandom);
        w.count = count;
        return w;
    endfunction

    function automatic logic signed [15:0] rand_axis(input int base);
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'(base + int'($urandom_range(0, 200)) - 100);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_delay(50);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.command     <= w.cmd;
        in_if.sample_x    <= w.x;
        in_if.sample_y    <= w.y;
        in_if.sample_z    <= w.z;
        in_if.calib_count <= w.count;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_word(w);
        words_sent++;
    endtask

    task automatic wait_results_done();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_default_count(input logic [8:0] value);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        dflt_count  = value;
    endtask

    // receiver stalls
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_pick = pick_delay(70);
            out_if.ready <= (stall_pick == 0);
            stall_left   <= (stall_pick == 0) ? 0 : stall_pick - 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word, kind %0d", out_if.kind);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_if.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
                    errors++;
                end
                if (out_if.out_x !== want.x) begin
                    $error("out_x: expected %0d, got %0d", want.x, out_if.out_x);
                    errors++;
                end
                if (out_if.out_y !== want.y) begin
                    $error("out_y: expected %0d, got %0d", want.y, out_if.out_y);
                    errors++;
                end
                if (out_if.out_z !== want.z) begin
                    $error("out_z: expected %0d, got %0d", want.z, out_if.out_z);
                    errors++;
                end
                if (out_if.pulse_level !== want.pulse) begin
                    $error("pulse_level: expected %0b, got %0b", want.pulse,
                           out_if.pulse_level);
                    errors++;
                end
                if (out_if.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, out_if.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_plain_extremes();
        send_word(sample_word(16'sh7fff, 16'sh8000, 16'sh0000));
        send_word(sample_word(16'sh8000, 16'shffff, 16'sh7fff));
        send_word(sample_word(16'sh0001, 16'sh7fff, 16'sh8000));
    endtask

    task automatic test_default_calibration();
        send_word(start_word(9'd0));
        send_word(start_word(9'd5));
        send_word(sample_word(16'sh7fff, 16'sh8000, 16'sd100));
        send_word(sample_word(16'sh7ffe, 16'sh8001, -16'sd37));
        send_word(sample_word(16'sh7fff, 16'sh8000, 16'sd5));
        send_word(sample_word(16'sh1234, 16'sh4321, 16'sh5555));
        send_word(sample_word(16'sh8000, 16'sh7fff, -16'sd200));
        send_word(sample_word(16'sh8001, 16'sh7ffe, 16'sd13));
        send_word(sample_word(16'sh8000, 16'sh7fff, -16'sd7));
        send_word(sample_word(16'sh7fff, 16'sh8000, 16'sh0000));
        send_word(sample_word(16'sh8000, 16'sh7fff, 16'shffff));
    endtask

    task automatic test_count_rejects();
        send_word(start_word(9'd257));
        send_word(start_word(9'd511));
        write_default_count(9'd0);
        send_word(start_word(9'd0));
        write_default_count(9'd511);
        send_word(start_word(9'd0));
    endtask

    task automatic test_single_sample_calibration();
        write_default_count(9'd1);
        send_word(start_word(9'd0));
        send_word(sample_word(16'sd1000, -16'sd1000, 16'sd3));
        send_word(sample_word(16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_word(sample_word(-16'sd999, 16'sd999, -16'sd4));
        // sender holds off until every result is back
        wait_results_done();
        send_word(sample_word(16'sd0, 16'sd0, 16'sd0));
    endtask

    task automatic test_full_length_calibration();
        write_default_count(9'd256);
        send_word(start_word(9'd0));
        repeat (MAX_COUNT) send_word(sample_word(16'sh8000, 16'sh7fff, 16'($urandom)));
        send_word(sample_word(16'($urandom), 16'($urandom), 16'($urandom)));
        repeat (MAX_COUNT) send_word(sample_word(16'sh7fff, 16'sh8000, 16'($urandom)));
        send_word(sample_word(16'sh7fff, 16'sh8000, 16'sh0000));
        write_default_count(9'd3);
    endtask

    task automatic test_random_traffic();
        int         stop_at;
        int         r;
        int         n;
        int         eff;
        int         cut;
        int         bx;
        int         by;
        int         bz;
        logic [8:0] cnt;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            no_idle = ($urandom_range(0, 99) < 15);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                n = $urandom_range(0, 99);
                if (n < 80)
                    n = $urandom_range(1, 8);
                else if (n < 97)
                    n = $urandom_range(9, 32);
                else
                    n = $urandom_range(200, MAX_COUNT);
                cnt = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'(n);
                eff = (cnt == 0) ? int'(dflt_count) : n;
                if (eff == 0 || eff > MAX_COUNT)
                    eff = 2;
                cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2 * eff) : 2 * eff + 1;
                bx = $urandom_range(0, 60000) - 30000;
                by = $urandom_range(0, 60000) - 30000;
                bz = $urandom_range(0, 60000) - 30000;
                send_word(start_word(cnt));
                for (int i = 0; i < cut; i++) begin
                    if ($urandom_range(0, 99) < 3)
                        send_word(start_word(9'($urandom)));
                    if (i <= eff)
                        send_word(sample_word(rand_axis(bx), rand_axis(by), rand_axis(bz)));
                    else
                        send_word(sample_word(rand_axis(-bx), rand_axis(-by), rand_axis(-bz)));
                end
            end else if (r < 85) begin
                repeat ($urandom_range(1, 10))
                    send_word(sample_word(16'($urandom), 16'($urandom), 16'($urandom)));
            end else if (r < 95) begin
                send_word(start_word(($urandom_range(0, 1) == 0) ? 9'($urandom_range(257, 511))
                                                                  : 9'($urandom)));
            end else if (cal_state == CAL_IDLE) begin
                case ($urandom_range(0, 4))
                    0: write_default_count(9'd0);
                    1: write_default_count(9'd1);
                    2: write_default_count(9'd256);
                    3: write_default_count(9'($urandom_range(257, 511)));
                    default: write_default_count(9'($urandom_range(2, 12)));
                endcase
            end else begin
                wait_results_done();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        in_if.valid       = 1'b0;
        in_if.command     = 1'b0;
        in_if.sample_x    = '0;
        in_if.sample_y    = '0;
        in_if.sample_z    = '0;
        in_if.calib_count = '0;
        out_if.ready      = 1'b0;
        stall_left        = 0;
        errors            = 0;
        words_sent        = 0;
        no_idle           = 1'b0;
        dflt_count        = mfoc_pkg::DEFAULT_SAMPLES;
        cal_state         = CAL_IDLE;
        phase_seen        = 0;
        phase_len         = 0;
        drop_next         = 1'b0;
        pulse_line        = 1'b0;
        for (int a = 0; a < 3; a++) begin
            norm_sum[a]  = '0;
            inv_sum[a]   = '0;
            axis_offs[a] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_extremes();
        test_default_calibration();
        test_count_rejects();
        test_single_sample_calibration();
        test_full_length_calibration();
        test_random_traffic();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected result words never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("[mag_flip_offset_calibrator] OK");
        else
            $display("[mag_flip_offset_calibrator] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[mag_flip_offset_calibrator] ERROR");
        $finish;
    end

endmodule
